>>> rtl/atrkm_pkg.sv
`timescale 1ns / 1ps

package atrkm_pkg;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_REARM = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    PH_ECHO    = 2'd0,
    PH_RESP    = 2'd1,
    PH_FOUND   = 2'd2,
    PH_TIMEOUT = 2'd3
  } phase_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int TIME_W     = 18;
  localparam int KLEN_W     = 4;
  localparam int KEY_TEXT_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_START_PHASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_TEXT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH     = 3'd4;

  localparam logic [7:0]        CH_LF   = 8'd10;
  localparam logic [7:0]        CH_CR   = 8'd13;
  localparam logic [TIME_W-1:0] TICK_MS = 18'd10;

endpackage

>>> rtl/atrkm_match.sv
`timescale 1ns / 1ps

module atrkm_match #(
  parameter int KEY_MAX = 8,
  parameter int CNT_W   = 8
) (
  input  logic [KEY_MAX*8-1:0]              window,
  input  logic [atrkm_pkg::KEY_TEXT_W-1:0]  key_text,
  input  logic [atrkm_pkg::KLEN_W-1:0]      key_len,
  input  logic [CNT_W-1:0]                  count,
  output logic                              match
);
  import atrkm_pkg::*;

  localparam int CW = (CNT_W > KLEN_W) ? CNT_W : KLEN_W;

  logic [KEY_MAX-1:0] eq [1:KEY_MAX];
  logic [KEY_MAX:1]   len_hit;
  logic               sel_hit;

  // For a key of length l, key character i must equal the byte received
  // l-1-i beats ago.
  for (genvar l = 1; l <= KEY_MAX; l++) begin : g_len
    for (genvar i = 0; i < KEY_MAX; i++) begin : g_chr
      if (i < l) begin : g_use
        assign eq[l][i] = (key_text[8*i +: 8] == window[8*(l-1-i) +: 8]);
      end else begin : g_pad
        assign eq[l][i] = 1'b1;
      end
    end
    assign len_hit[l] = &eq[l];
  end

  always_comb begin
    sel_hit = 1'b0;
    for (int l = 1; l <= KEY_MAX; l++) begin
      if (key_len == KLEN_W'(l)) begin
        sel_hit = len_hit[l];
      end
    end
  end

  assign match = sel_hit && (key_len != '0) && (CW'(count) >= CW'(key_len));

endmodule

>>> rtl/at_response_key_matcher.sv
`timescale 1ns / 1ps
// An input beat passes through an input register, then a result register, with the
// whole state update registered together with the result.
// Throughput: one item per cycle; while a result waits the input register
// takes one more beat, then the input stalls until the result is taken.
// Reset clears all configuration registers, the tracking state and both stages.

module at_response_key_matcher #(
  parameter int ECHO_BUF_SIZE  = 64,
  parameter int REPLY_BUF_SIZE = 256,
  parameter int KEY_MAX        = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] data_byte
  input  logic [1:0]                        s_tuser,   // [1:0] opcode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,   // [1:0] phase, [2] overflow
  input  logic                              cfg_we,
  input  logic [atrkm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [atrkm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import atrkm_pkg::*;

  localparam int ECHO_W  = $clog2(ECHO_BUF_SIZE);
  localparam int REPLY_W = $clog2(REPLY_BUF_SIZE);
  localparam int WIN_W   = KEY_MAX * 8;
  localparam logic [ECHO_W-1:0]  ECHO_LIMIT  = ECHO_W'(ECHO_BUF_SIZE - 2);
  localparam logic [REPLY_W-1:0] REPLY_LIMIT = REPLY_W'(REPLY_BUF_SIZE - 2);

  logic                  start_phase;
  logic [TIME_W-1:0]     timeout_ms;
  logic                  timeout_enable;
  logic [KEY_TEXT_W-1:0] key_text;
  logic [KLEN_W-1:0]     key_length;

  phase_t                cur_phase, cur_phase_next;
  logic [ECHO_W-1:0]     echo_count, echo_count_next;
  logic [REPLY_W-1:0]    reply_count, reply_count_next;
  logic [WIN_W-1:0]      recent_bytes, recent_bytes_next;
  logic                  key_seen, key_seen_next;
  logic [TIME_W-1:0]     time_left, time_left_next;

  logic                  in_valid;
  opcode_t               in_opcode;
  logic [7:0]            in_byte;
  logic                  advance;
  logic                  ovf_next;
  logic [KLEN_W-1:0]     len_in_use;
  logic [REPLY_W-1:0]    reply_inc;
  logic [WIN_W+7:0]      win_wide;
  logic [WIN_W-1:0]      win_shift;
  logic                  match;

  phase_t                out_phase;
  logic                  out_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_phase    <= 1'b0;
      timeout_ms     <= '0;
      timeout_enable <= 1'b0;
      key_text       <= '0;
      key_length     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_PHASE:    start_phase    <= cfg_data[0];
        CFG_TIMEOUT_MS:     timeout_ms     <= cfg_data[TIME_W-1:0];
        CFG_TIMEOUT_ENABLE: timeout_enable <= cfg_data[0];
        CFG_KEY_TEXT:       key_text       <= cfg_data[KEY_TEXT_W-1:0];
        CFG_KEY_LENGTH:     key_length     <= cfg_data[KLEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_opcode <= opcode_t'(s_tuser);
      in_byte   <= s_tdata;
    end
  end

  assign len_in_use = (KLEN_W'(KEY_MAX) < key_length) ? '0 : key_length;
  assign reply_inc  = reply_count + 1'b1;
  assign win_wide   = {recent_bytes, in_byte};
  assign win_shift  = win_wide[WIN_W-1:0];

  atrkm_match #(
    .KEY_MAX (KEY_MAX),
    .CNT_W   (REPLY_W)
  ) u_match (
    .window   (win_shift),
    .key_text (key_text),
    .key_len  (len_in_use),
    .count    (reply_inc),
    .match    (match)
  );

  always_comb begin
    cur_phase_next    = cur_phase;
    echo_count_next   = echo_count;
    reply_count_next  = reply_count;
    recent_bytes_next = recent_bytes;
    key_seen_next     = key_seen;
    time_left_next    = time_left;
    ovf_next          = 1'b0;
    case (in_opcode)
      OP_BYTE: begin
        if (in_byte != CH_LF) begin
          if (cur_phase == PH_ECHO) begin
            if (echo_count >= ECHO_LIMIT) begin
              ovf_next = 1'b1;
            end else begin
              echo_count_next = echo_count + 1'b1;
              if (in_byte == CH_CR) begin
                cur_phase_next = PH_RESP;
              end
            end
          end else begin
            if (reply_count >= REPLY_LIMIT) begin
              ovf_next = 1'b1;
            end else begin
              reply_count_next  = reply_inc;
              recent_bytes_next = win_shift;
              key_seen_next     = key_seen || match;
              if ((len_in_use != '0) && (key_seen || match)) begin
                cur_phase_next = PH_FOUND;
              end
            end
          end
        end
      end
      OP_TICK: begin
        if ((time_left != '0) && timeout_enable) begin
          if (time_left > TICK_MS) begin
            time_left_next = time_left - TICK_MS;
          end else begin
            time_left_next = '0;
            cur_phase_next = PH_TIMEOUT;
          end
        end
      end
      OP_REARM: begin
        cur_phase_next    = start_phase ? PH_RESP : PH_ECHO;
        time_left_next    = timeout_ms;
        echo_count_next   = '0;
        reply_count_next  = '0;
        recent_bytes_next = '0;
        key_seen_next     = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_phase    <= PH_ECHO;
      echo_count   <= '0;
      reply_count  <= '0;
      recent_bytes <= '0;
      key_seen     <= 1'b0;
      time_left    <= '0;
      m_tvalid     <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
      if (in_valid) begin
        cur_phase    <= cur_phase_next;
        echo_count   <= echo_count_next;
        reply_count  <= reply_count_next;
        recent_bytes <= recent_bytes_next;
        key_seen     <= key_seen_next;
        time_left    <= time_left_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_phase <= cur_phase_next;
      out_ovf   <= ovf_next;
    end
  end

  assign m_tdata = {5'd0, out_ovf, out_phase};

endmodule

>>> tb/at_response_key_matcher_tb.sv
`timescale 1ns / 1ps

module at_response_key_matcher_tb;
  import atrkm_pkg::*;

  localparam int ECHO_LIMIT     = 62;
  localparam int REPLY_LIMIT    = 254;
  localparam int KEY_CHARS      = 8;
  localparam int SETTLE_CYCLES  = 6;
  localparam int HOLD_CYCLES    = 200;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int MAX_PRINTED    = 50;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic   overflow;
    phase_t phase;
  } status_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'd0;
  logic [1:0]            s_tuser = 2'd0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_START_PHASE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic idle_on = 1'b1;
  logic hold_request = 1'b0;
  logic hold_active = 1'b0;
  int   sink_gap = 0;
  int   cycle_count = 0;
  int   mismatches = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   found_seen = 0;
  int   timeout_seen = 0;
  int   overflow_seen = 0;

  logic                  reg_start_phase = 1'b0;
  logic [TIME_W-1:0]     reg_timeout_ms = '0;
  logic                  reg_timeout_en = 1'b0;
  logic [KEY_TEXT_W-1:0] reg_key_text = '0;
  logic [KLEN_W-1:0]     reg_key_length = '0;

  phase_t            trk_phase = PH_ECHO;
  int                trk_echo_count = 0;
  int                trk_reply_count = 0;
  logic [63:0]       trk_window = '0;
  logic              trk_key_seen = 1'b0;
  logic [TIME_W-1:0] trk_time_left = '0;

  status_t pending_status[$];

  at_response_key_matcher uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d beats outstanding", cycle_count,
               pending_status.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_active) begin
      m_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      m_tready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      sink_gap <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin : sink_hold
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request <= 1'b0;
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("Mismatch at %0t ns: %s is %0d, expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    status_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      results_seen++;
      if (m_tdata[1:0] == PH_FOUND) found_seen++;
      if (m_tdata[1:0] == PH_TIMEOUT) timeout_seen++;
      if (m_tdata[2]) overflow_seen++;
      if (pending_status.size() == 0) begin
        report_mismatch("unexpected result beat", m_tdata, 0);
      end else begin
        want = pending_status.pop_front();
        if (m_tdata[1:0] !== want.phase) report_mismatch("phase", m_tdata[1:0], want.phase);
        if (m_tdata[2] !== want.overflow) report_mismatch("overflow", m_tdata[2], want.overflow);
      end
    end
  end

  function automatic void track_item(input logic [1:0] op, input logic [7:0] ch);
    status_t st;
    int      key_len;
    logic    hit;
    st.overflow = 1'b0;
    case (op)
      OP_BYTE: begin
        if (ch != CH_LF) begin
          if (trk_phase == PH_ECHO) begin
            if (trk_echo_count >= ECHO_LIMIT) begin
              st.overflow = 1'b1;
            end else begin
              trk_echo_count++;
              if (ch == CH_CR) trk_phase = PH_RESP;
            end
          end else if (trk_reply_count >= REPLY_LIMIT) begin
            st.overflow = 1'b1;
          end else begin
            key_len = (reg_key_length > KEY_CHARS) ? 0 : int'(reg_key_length);
            trk_reply_count++;
            trk_window = {trk_window[55:0], ch};
            hit = (key_len > 0) && (trk_reply_count >= key_len);
            for (int i = 0; i < key_len; i++)
              if (reg_key_text[8*i +: 8] != trk_window[8*(key_len-1-i) +: 8]) hit = 1'b0;
            if (hit) trk_key_seen = 1'b1;
            if (key_len > 0 && trk_key_seen) trk_phase = PH_FOUND;
          end
        end
      end
      OP_TICK: begin
        if (trk_time_left != 0 && reg_timeout_en) begin
          if (trk_time_left > TICK_MS) begin
            trk_time_left = trk_time_left - TICK_MS;
          end else begin
            trk_time_left = '0;
            trk_phase = PH_TIMEOUT;
          end
        end
      end
      OP_REARM: begin
        trk_phase = reg_start_phase ? PH_RESP : PH_ECHO;
        trk_time_left = reg_timeout_ms;
        trk_echo_count = 0;
        trk_reply_count = 0;
        trk_window = '0;
        trk_key_seen = 1'b0;
      end
      default: ;
    endcase
    st.phase = trk_phase;
    pending_status.push_back(st);
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] ch);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= ch;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    track_item(op, ch);
    items_sent++;
  endtask

  // Stray line feeds, ticks, unused opcodes and the odd rearm mixed into a stream.
  task automatic send_with_noise(input logic [1:0] op, input logic [7:0] ch);
    case ($urandom_range(0, 39))
      0, 1: send_item(OP_BYTE, CH_LF);
      2, 3: send_item(OP_TICK, 8'($urandom));
      4: send_item(OP_UNUSED, 8'($urandom));
      5: if ($urandom_range(0, 3) == 0) send_item(OP_REARM, 8'($urandom));
      default: ;
    endcase
    send_item(op, ch);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == CH_CR || b == CH_LF) b = b ^ 8'h40;
    return b;
  endfunction

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic start, input logic [TIME_W-1:0] tmo, input logic en,
                          input logic [KEY_TEXT_W-1:0] text, input logic [KLEN_W-1:0] len);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_START_PHASE;
    cfg_data <= CFG_DATA_W'(start);
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT_MS;
    cfg_data <= CFG_DATA_W'(tmo);
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT_ENABLE;
    cfg_data <= CFG_DATA_W'(en);
    @(posedge clk);
    cfg_index <= CFG_KEY_TEXT;
    cfg_data <= CFG_DATA_W'(text);
    @(posedge clk);
    cfg_index <= CFG_KEY_LENGTH;
    cfg_data <= CFG_DATA_W'(len);
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_start_phase = start;
    reg_timeout_ms = tmo;
    reg_timeout_en = en;
    reg_key_text = text;
    reg_key_length = len;
  endtask

  // One command exchange: random registers, rearm, echo, carriage return, then a reply
  // that usually carries the key somewhere, with ticks along the way.
  task automatic run_session();
    logic [TIME_W-1:0]     tmo;
    logic [KLEN_W-1:0]     klen;
    logic [KEY_TEXT_W-1:0] key;
    int                    n_echo;
    int                    n_resp;
    int                    key_at;
    int                    used;
    case ($urandom_range(0, 9))
      0: tmo = '0;
      1: tmo = '1;
      2: tmo = TIME_W'($urandom);
      default: tmo = TIME_W'($urandom_range(1, 120));
    endcase
    if ($urandom_range(0, 9) == 0) klen = KLEN_W'($urandom_range(9, 15));
    else klen = KLEN_W'($urandom_range(0, 8));
    key = {$urandom, $urandom};
    set_regs(1'($urandom), tmo, ($urandom_range(0, 4) != 0), key, klen);
    send_item(OP_REARM, 8'($urandom));
    n_echo = ($urandom_range(0, 12) == 0) ? $urandom_range(58, 70) : $urandom_range(0, 10);
    for (int i = 0; i < n_echo; i++) send_with_noise(OP_BYTE, plain_byte());
    send_with_noise(OP_BYTE, CH_CR);
    n_resp = ($urandom_range(0, 12) == 0) ? $urandom_range(250, 262) : $urandom_range(0, 24);
    used = (klen > KEY_CHARS) ? KEY_CHARS : int'(klen);
    key_at = ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, n_resp);
    for (int i = 0; i <= n_resp; i++) begin
      if (i == key_at)
        for (int k = 0; k < used; k++) send_with_noise(OP_BYTE, key[8*k +: 8]);
      if (i < n_resp) send_with_noise(OP_BYTE, plain_byte());
      if ($urandom_range(0, 5) == 0) send_item(OP_TICK, 8'($urandom));
    end
  endtask

  task automatic test_after_reset();
    send_item(OP_TICK, 8'h00);
    send_item(OP_UNUSED, 8'hFF);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, CH_LF);
    send_item(OP_BYTE, CH_CR);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, CH_CR);
    settle();
  endtask

  // The key is seen, the timer runs out, and a later byte still reports the key.
  task automatic test_key_and_timer();
    set_regs(1'b1, 18'd25, 1'b1, 64'h4B4F, 4'd2);
    send_item(OP_REARM, 8'h00);
    send_item(OP_BYTE, 8'h4F);
    send_item(OP_BYTE, 8'h4B);
    send_item(OP_BYTE, 8'h78);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, 8'h5A);
    send_item(OP_REARM, 8'hFF);
    send_item(OP_BYTE, 8'h4B);
    settle();
  endtask

  task automatic test_key_limits();
    set_regs(1'b1, '1, 1'b0, 64'h0706050403020100, 4'd8);
    send_item(OP_REARM, 8'h00);
    for (int i = 0; i < KEY_CHARS; i++) send_item(OP_BYTE, 8'(i));
    set_regs(1'b1, '1, 1'b0, '1, 4'd15);
    send_item(OP_REARM, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_TICK, 8'h00);
    settle();
  endtask

  task automatic test_echo_overflow();
    set_regs(1'b0, 18'd0, 1'b0, {$urandom, $urandom}, 4'd4);
    send_item(OP_REARM, 8'h00);
    for (int i = 0; i < ECHO_LIMIT; i++) send_item(OP_BYTE, plain_byte());
    send_item(OP_BYTE, CH_CR);
    send_item(OP_BYTE, plain_byte());
    send_item(OP_BYTE, CH_LF);
    send_item(OP_REARM, 8'h00);
    send_item(OP_BYTE, CH_CR);
    settle();
  endtask

  task automatic test_reply_overflow();
    set_regs(1'b1, 18'd0, 1'b0, 64'h41, 4'd1);
    send_item(OP_REARM, 8'h00);
    for (int i = 0; i < REPLY_LIMIT - 1; i++) send_item(OP_BYTE, plain_byte());
    send_item(OP_BYTE, 8'h41);
    send_item(OP_BYTE, 8'h41);
    send_item(OP_BYTE, CH_CR);
    send_item(OP_REARM, 8'h00);
    settle();
  endtask

  // The sink stops taking beats for a long stretch while bytes keep coming.
  task automatic test_receiver_hold();
    set_regs(1'b0, 18'd40, 1'b1, 64'h4B4F, 4'd2);
    hold_request <= 1'b1;
    send_item(OP_REARM, 8'h00);
    for (int i = 0; i < 6; i++) send_item(OP_BYTE, plain_byte());
    send_item(OP_BYTE, CH_CR);
    for (int i = 0; i < 12; i++) send_item(OP_BYTE, plain_byte());
    send_item(OP_BYTE, 8'h4F);
    send_item(OP_BYTE, 8'h4B);
    send_item(OP_TICK, 8'h00);
    settle();
  endtask

  task automatic test_random_sessions();
    int stop_at;
    stop_at = items_sent + 800;
    while (items_sent < stop_at) run_session();
    settle();
  endtask

  task automatic test_steady_stream();
    int stop_at;
    idle_on <= 1'b0;
    stop_at = items_sent + 200;
    while (items_sent < stop_at) run_session();
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_after_reset();
    test_key_and_timer();
    test_key_limits();
    test_echo_overflow();
    test_reply_overflow();
    test_receiver_hold();
    test_random_sessions();
    test_steady_stream();
    $display("Sent %0d items and checked %0d result beats in %0d cycles.", items_sent,
             results_seen, cycle_count);
    $display("Beats showing key found: %0d, timed out: %0d, overflow: %0d.", found_seen,
             timeout_seen, overflow_seen);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches found", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
